[rtl/core/intruder_alarm_controller_assert.svh]
// Assertion macros shared by the intruder alarm controller checkers.
// Needs a clock named clock and a reset named reset in the including scope.
`ifndef INTRUDER_ALARM_CONTROLLER_ASSERT_SVH
`define INTRUDER_ALARM_CONTROLLER_ASSERT_SVH

// Condition in one cycle implies a consequence in the same cycle.
`define IAC_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define IAC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/iac_pkg.sv]
// Types, mode codes and counter helpers for the intruder alarm controller.
// No dependencies; used by the top level, iac_fsm and iac_checker.
package iac_pkg;

   localparam int CounterWidth = 8;
   localparam int LimWidth     = (CounterWidth > 8) ? CounterWidth : 8;
   localparam logic [LimWidth-1:0] CountMax = LimWidth'((1 << CounterWidth) - 1);

   localparam logic [2:0] MODE_OFF    = 3'd0;
   localparam logic [2:0] MODE_ARMING = 3'd1;
   localparam logic [2:0] MODE_ARMED  = 3'd2;
   localparam logic [2:0] MODE_TRIG   = 3'd3;
   localparam logic [2:0] MODE_SOUND  = 3'd4;

   localparam logic [2:0] PAT_DARK  = 3'b000;
   localparam logic [2:0] PAT_LED1  = 3'b001;
   localparam logic [2:0] PAT_LED2  = 3'b010;
   localparam logic [2:0] PAT_BOTH  = 3'b011;
   localparam logic [2:0] PAT_BUZZ  = 3'b100;
   localparam logic [2:0] PAT_ALL   = 3'b111;

   localparam logic [2:0] REG_OFF_HOLDOFF  = 3'd0;
   localparam logic [2:0] REG_ARM_HALF     = 3'd1;
   localparam logic [2:0] REG_ARM_CYCLES   = 3'd2;
   localparam logic [2:0] REG_WARN_GAP     = 3'd3;
   localparam logic [2:0] REG_WARN_FLASH   = 3'd4;
   localparam logic [2:0] REG_WARN_CYCLES  = 3'd5;
   localparam logic [2:0] REG_SOUND_HALF   = 3'd6;

   typedef struct packed {
      logic [7:0] off_holdoff_ticks;
      logic [7:0] arm_half_period;
      logic [3:0] arm_cycles;
      logic [7:0] warn_gap_ticks;
      logic [7:0] warn_flash_ticks;
      logic [3:0] warn_cycles;
      logic [7:0] sound_half_period;
   } cfg_type;

   typedef struct packed {
      logic [2:0]              mode;
      logic [CounterWidth-1:0] tick_count;
      logic [3:0]              cycle_count;
      logic                    phase;
      logic [2:0]              led_pattern;
   } state_type;

   typedef struct packed {
      logic [2:0] mode_code;
      logic       notify_pulse;
      logic       buzzer_on;
      logic       led_two;
      logic       led_one;
   } result_type;

   typedef struct packed {
      logic                    done;
      logic [CounterWidth-1:0] tick_count;
   } count_type;

   function automatic logic [LimWidth-1:0] period_limit(input logic [7:0] len);
      logic [LimWidth-1:0] v;
      v = LimWidth'(len);
      if (v == '0) begin
         v = LimWidth'(1);
      end
      if (v > CountMax) begin
         v = CountMax;
      end
      return v;
   endfunction

   function automatic count_type count_tick(input logic [CounterWidth-1:0] tick,
                                            input logic [7:0] len);
      count_type r;
      logic [LimWidth-1:0] t;
      t = LimWidth'(tick);
      if (t < CountMax) begin
         t = t + LimWidth'(1);
      end
      r.done = (t >= period_limit(len));
      r.tick_count = r.done ? '0 : CounterWidth'(t);
      return r;
   endfunction

   function automatic logic [3:0] cycle_limit(input logic [3:0] v);
      return (v == 4'd0) ? 4'd1 : v;
   endfunction

endpackage

[rtl/core/intruder_alarm_controller.sv]
// Intruder alarm controller, top level: stream ports, settings registers,
// mode state and a two-entry result buffer. Depends on iac_pkg and iac_fsm.
//
// One beat per 0.1 s tick goes in and exactly one result beat comes out. A tick
// beat is taken in every cycle while the buffer has room: the mode machine is a
// single pass of logic into the state and result registers; its result is
// registered into the output register, or into the skid stage behind it while
// an earlier result waits, so req_tready drops only when two results wait;
// req_tready does not depend on rsp_tready. Settings writes take effect at the
// next tick and should be made while no result is outstanding.
module intruder_alarm_controller (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [0] switch_pressed, [1] motion_seen, [7:2] zero
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [0] led_one, [1] led_two, [2] buzzer_on,
                                   // [3] notify_pulse, [6:4] mode_code, [7] zero
   input  logic       csr_we,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_wdata
);
   import iac_pkg::*;

   cfg_type    cfg_ff;
   state_type  state_ff;
   state_type  state_in;
   result_type result_in;
   result_type out_ff;
   result_type skid_ff;
   logic       out_valid_ff;
   logic       skid_valid_ff;
   logic       accept;
   logic       drain;

   iac_fsm u_iac_fsm (
      .cur_state      (state_ff),
      .cfg            (cfg_ff),
      .switch_pressed (req_tdata[0]),
      .motion_seen    (req_tdata[1]),
      .nxt_state      (state_in),
      .result         (result_in)
   );

   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign drain      = out_valid_ff && rsp_tready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{off_holdoff_ticks: 8'd10, arm_half_period: 8'd10, arm_cycles: 4'd5,
                     warn_gap_ticks: 8'd20, warn_flash_ticks: 8'd1, warn_cycles: 4'd5,
                     sound_half_period: 8'd20};
      end else if (csr_we) begin
         unique case (csr_index)
            REG_OFF_HOLDOFF: cfg_ff.off_holdoff_ticks <= csr_wdata;
            REG_ARM_HALF:    cfg_ff.arm_half_period   <= csr_wdata;
            REG_ARM_CYCLES:  cfg_ff.arm_cycles        <= csr_wdata[3:0];
            REG_WARN_GAP:    cfg_ff.warn_gap_ticks    <= csr_wdata;
            REG_WARN_FLASH:  cfg_ff.warn_flash_ticks  <= csr_wdata;
            REG_WARN_CYCLES: cfg_ff.warn_cycles       <= csr_wdata[3:0];
            REG_SOUND_HALF:  cfg_ff.sound_half_period <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{mode: MODE_OFF, tick_count: '0, cycle_count: '0,
                       phase: 1'b0, led_pattern: PAT_LED1};
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (drain) begin
         if (skid_valid_ff) begin
            out_ff        <= skid_ff;
            skid_valid_ff <= 1'b0;
         end else if (accept) begin
            out_ff <= result_in;
         end else begin
            out_valid_ff <= 1'b0;
         end
      end else if (accept) begin
         if (out_valid_ff) begin
            skid_ff       <= result_in;
            skid_valid_ff <= 1'b1;
         end else begin
            out_ff       <= result_in;
            out_valid_ff <= 1'b1;
         end
      end
   end

endmodule

[rtl/core/iac_fsm.sv]
// Next-state and result logic of the alarm mode machine for one tick.
// Depends on iac_pkg.
module iac_fsm (
   input  iac_pkg::state_type  cur_state,
   input  iac_pkg::cfg_type    cfg,
   input  logic                switch_pressed,
   input  logic                motion_seen,
   output iac_pkg::state_type  nxt_state,
   output iac_pkg::result_type result
);
   import iac_pkg::*;

   state_type s;
   count_type cnt;
   logic      notify;

   always_comb begin
      s      = cur_state;
      notify = 1'b0;
      cnt    = '{done: 1'b0, tick_count: '0};
      unique case (cur_state.mode)
         MODE_OFF: begin
            if (LimWidth'(cur_state.tick_count) < LimWidth'(cfg.off_holdoff_ticks) &&
                LimWidth'(cur_state.tick_count) < CountMax) begin
               s.tick_count = cur_state.tick_count + CounterWidth'(1);
            end else if (switch_pressed) begin
               s = '{mode: MODE_ARMING, tick_count: '0, cycle_count: '0,
                     phase: 1'b0, led_pattern: PAT_LED1};
            end
         end
         MODE_ARMING: begin
            cnt = count_tick(cur_state.tick_count, cfg.arm_half_period);
            s.tick_count = cnt.tick_count;
            if (cnt.done) begin
               if (!cur_state.phase) begin
                  s.phase       = 1'b1;
                  s.led_pattern = PAT_DARK;
               end else begin
                  s.phase       = 1'b0;
                  s.led_pattern = PAT_LED1;
                  s.cycle_count = cur_state.cycle_count + 4'd1;
                  if (s.cycle_count >= cycle_limit(cfg.arm_cycles)) begin
                     s = '{mode: MODE_ARMED, tick_count: '0, cycle_count: '0,
                           phase: 1'b0, led_pattern: PAT_LED2};
                  end
               end
            end
         end
         MODE_ARMED: begin
            if (switch_pressed) begin
               s = '{mode: MODE_OFF, tick_count: '0, cycle_count: '0,
                     phase: 1'b0, led_pattern: PAT_LED1};
            end else if (motion_seen) begin
               s = '{mode: MODE_TRIG, tick_count: '0, cycle_count: '0,
                     phase: 1'b0, led_pattern: PAT_DARK};
            end
         end
         MODE_TRIG: begin
            if (switch_pressed) begin
               s = '{mode: MODE_OFF, tick_count: '0, cycle_count: '0,
                     phase: 1'b0, led_pattern: PAT_LED1};
            end else if (!cur_state.phase) begin
               cnt = count_tick(cur_state.tick_count, cfg.warn_gap_ticks);
               s.tick_count = cnt.tick_count;
               if (cnt.done) begin
                  s.phase       = 1'b1;
                  s.led_pattern = PAT_BOTH;
               end
            end else begin
               cnt = count_tick(cur_state.tick_count, cfg.warn_flash_ticks);
               s.tick_count = cnt.tick_count;
               if (cnt.done) begin
                  s.phase       = 1'b0;
                  s.led_pattern = PAT_DARK;
                  s.cycle_count = cur_state.cycle_count + 4'd1;
                  if (s.cycle_count >= cycle_limit(cfg.warn_cycles)) begin
                     s = '{mode: MODE_SOUND, tick_count: '0, cycle_count: '0,
                           phase: 1'b0, led_pattern: PAT_ALL};
                     notify = 1'b1;
                  end
               end
            end
         end
         MODE_SOUND: begin
            if (switch_pressed) begin
               s = '{mode: MODE_OFF, tick_count: '0, cycle_count: '0,
                     phase: 1'b0, led_pattern: PAT_LED1};
            end else begin
               cnt = count_tick(cur_state.tick_count, cfg.sound_half_period);
               s.tick_count = cnt.tick_count;
               if (cnt.done) begin
                  s.phase       = !cur_state.phase;
                  s.led_pattern = s.phase ? PAT_BUZZ : PAT_ALL;
               end
            end
         end
         default: begin
            s = '{mode: MODE_OFF, tick_count: '0, cycle_count: '0,
                  phase: 1'b0, led_pattern: PAT_LED1};
         end
      endcase
   end

   assign nxt_state           = s;
   assign result.led_one      = s.led_pattern[0];
   assign result.led_two      = s.led_pattern[1];
   assign result.buzzer_on    = s.led_pattern[2];
   assign result.notify_pulse = notify;
   assign result.mode_code    = s.mode;

endmodule

[rtl/core/iac_checker.sv]
// Port-level checks on the result stream of the intruder alarm controller.
// Depends on intruder_alarm_controller_assert.svh; bound to the top level below.
`include "intruder_alarm_controller_assert.svh"

module iac_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);
   import iac_pkg::*;

   `IAC_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result beat changed while stalled")
   `IAC_ASSERT_SAME(a_notify_sound, rsp_tvalid && rsp_tdata[3], rsp_tdata[6:4] == MODE_SOUND && rsp_tdata[2:0] == PAT_ALL, "notify without entering sounding")
   `IAC_ASSERT_SAME(a_buzz_sound, rsp_tvalid, rsp_tdata[2] == (rsp_tdata[6:4] == MODE_SOUND), "buzzer does not match sounding mode")
   `IAC_ASSERT_SAME(a_off_leds, rsp_tvalid && rsp_tdata[6:4] == MODE_OFF, rsp_tdata[2:0] == PAT_LED1, "off mode without only LED1 lit")

endmodule

bind intruder_alarm_controller iac_checker u_iac_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
